// File: sv/bsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the barometric compensation core.
// No dependencies; imported by the core and the divider.
package bsc_pkg;

    // Field widths
    localparam int unsigned RAW_W   = 20;
    localparam int unsigned TEMP_W  = 15;
    localparam int unsigned PRESS_W = 25;
    localparam int unsigned CAL_W   = 32;
    localparam int unsigned ADDR_W  = 5;

    // Output limits
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRESS_MAX = 33554431;

    // Divider geometry: quotient bits, remainder and divisor widths
    localparam int unsigned QUOT_BITS = 37;
    localparam int unsigned UD_W      = 39;
    localparam int unsigned REM_W     = UD_W + QUOT_BITS;
    localparam logic [QUOT_BITS-1:0] QUOT_LIMIT = QUOT_BITS'(1) << (QUOT_BITS - 1);

    // Scale of the quotient: 6250 / 2
    localparam logic [11:0] QUOT_SCALE = 12'd3125;

    // Register map
    typedef enum logic [2:0] {
        REG_CAL_T1_T2 = 3'd0,
        REG_CAL_T3_P1 = 3'd1,
        REG_CAL_P2_P3 = 3'd2,
        REG_CAL_P4_P5 = 3'd3,
        REG_CAL_P6_P7 = 3'd4,
        REG_CAL_P8_P9 = 3'd5
    } t_reg_idx;

    // Sideband that rides along with the divider
    typedef struct packed {
        logic                     neg;
        logic                     zero;
        logic                     sat;
        logic signed [TEMP_W-1:0] temp;
    } t_side;

endpackage

// File: sv/barometric_sensor_compensation_core.sv
`timescale 1ns / 1ps
// Barometric temperature and pressure compensation core.
//
// Input channel: i_in_valid / o_in_stall carry one request of a raw
// 20-bit temperature and raw 20-bit pressure conversion. Output channel:
// o_out_valid / i_out_stall carry the compensated temperature (centi-degC,
// saturated), pressure (Pa, Q17.8, saturated) and a flag that is low when
// the pressure divisor came out zero.
// A new request can enter every cycle unless o_in_stall is raised. The pipe
// is the 37-stage divider, one quotient bit per stage, plus twelve
// stages in front and five behind it.
// When the receiver stalls, the output register holds; stages behind it
// keep moving until they fill, and only then is o_in_stall raised. A bubble
// anywhere in the pipe lets a new request in.
// Reset empties the pipe and clears the six calibration registers; the
// block takes requests in the first cycle after reset.
// The user must write calibration over the APB port only while no request is in flight; the block does not enforce it.
// Depends on bsc_pkg and bsc_div.
module barometric_sensor_compensation_core import bsc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [CAL_W-1:0]          pwdata,
    output logic [CAL_W-1:0]          prdata,
    output logic                      pready,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [RAW_W-1:0]          i_raw_temperature,
    input  logic [RAW_W-1:0]          i_raw_pressure,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [TEMP_W-1:0]  o_temperature_centi,
    output logic [PRESS_W-1:0]        o_pressure_q8,
    output logic                      o_pressure_valid
);

    localparam int unsigned N_FRONT = 12;
    localparam int unsigned N_BACK  = 5;
    localparam int unsigned NST     = N_FRONT + QUOT_BITS + N_BACK;
    localparam int unsigned ST_P1   = N_FRONT + QUOT_BITS;
    localparam int unsigned ST_P2   = ST_P1 + 1;
    localparam int unsigned ST_P3   = ST_P1 + 2;
    localparam int unsigned ST_P4   = ST_P1 + 3;
    localparam int unsigned ST_OUT  = ST_P1 + 4;

    //--------------------------------------------------------------------
    // Calibration registers
    //--------------------------------------------------------------------
    logic [CAL_W-1:0] r_cal_t1_t2, r_cal_t3_p1, r_cal_p2_p3;
    logic [CAL_W-1:0] r_cal_p4_p5, r_cal_p6_p7, r_cal_p8_p9;
    t_reg_idx         w_ridx;
    logic             w_wr;

    assign w_ridx = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write the addressed register, drop writes beyond the map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t1_t2 <= '0;
            r_cal_t3_p1 <= '0;
            r_cal_p2_p3 <= '0;
            r_cal_p4_p5 <= '0;
            r_cal_p6_p7 <= '0;
            r_cal_p8_p9 <= '0;
        end else if (w_wr) begin
            unique case (w_ridx)
                REG_CAL_T1_T2: r_cal_t1_t2 <= pwdata;
                REG_CAL_T3_P1: r_cal_t3_p1 <= pwdata;
                REG_CAL_P2_P3: r_cal_p2_p3 <= pwdata;
                REG_CAL_P4_P5: r_cal_p4_p5 <= pwdata;
                REG_CAL_P6_P7: r_cal_p6_p7 <= pwdata;
                REG_CAL_P8_P9: r_cal_p8_p9 <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_ridx)
            REG_CAL_T1_T2: prdata = r_cal_t1_t2;
            REG_CAL_T3_P1: prdata = r_cal_t3_p1;
            REG_CAL_P2_P3: prdata = r_cal_p2_p3;
            REG_CAL_P4_P5: prdata = r_cal_p4_p5;
            REG_CAL_P6_P7: prdata = r_cal_p6_p7;
            REG_CAL_P8_P9: prdata = r_cal_p8_p9;
            default:       prdata = '0;
        endcase
    end

    // Unpack coefficients
    logic [15:0]        w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_cal_t1_t2[15:0];
    assign w_t2 = r_cal_t1_t2[31:16];
    assign w_t3 = r_cal_t3_p1[15:0];
    assign w_p1 = r_cal_t3_p1[31:16];
    assign w_p2 = r_cal_p2_p3[15:0];
    assign w_p3 = r_cal_p2_p3[31:16];
    assign w_p4 = r_cal_p4_p5[15:0];
    assign w_p5 = r_cal_p4_p5[31:16];
    assign w_p6 = r_cal_p6_p7[15:0];
    assign w_p7 = r_cal_p6_p7[31:16];
    assign w_p8 = r_cal_p8_p9[15:0];
    assign w_p9 = r_cal_p8_p9[31:16];

    //--------------------------------------------------------------------
    // Valid chain: a stage loads when it is empty or everything after it
    // can move
    //--------------------------------------------------------------------
    logic [NST-1:0] r_vld, n_vld, w_go;

    for (genvar k = 0; k < NST; k++) begin : g_go
        assign w_go[k] = ~(&r_vld[NST-1:k]) | ~i_out_stall;
    end

    assign n_vld = (w_go & {r_vld[NST-2:0], i_in_valid}) | (~w_go & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = ~w_go[0];
    assign o_out_valid = r_vld[NST-1];

    //--------------------------------------------------------------------
    // S1: temperature differences
    //--------------------------------------------------------------------
    logic signed [17:0] r1_x1;
    logic signed [16:0] r1_x2;
    logic [RAW_W-1:0]   r1_ap;
    logic [17:0]        n1_x1;
    logic [16:0]        n1_x2;

    assign n1_x1 = {1'b0, i_raw_temperature[19:3]} - {1'b0, w_t1, 1'b0};
    assign n1_x2 = {1'b0, i_raw_temperature[19:4]} - {1'b0, w_t1};

    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r1_x1 <= n1_x1;
            r1_x2 <= n1_x2;
            r1_ap <= i_raw_pressure;
        end
    end

    //--------------------------------------------------------------------
    // S2: first-order product and square
    //--------------------------------------------------------------------
    logic signed [33:0] r2_m1, n2_m1, n2_sq;
    logic [31:0]        r2_sq;
    logic [RAW_W-1:0]   r2_ap;

    assign n2_m1 = r1_x1 * w_t2;
    assign n2_sq = r1_x2 * r1_x2;

    always_ff @(posedge i_clk) begin
        if (w_go[1]) begin
            r2_m1 <= n2_m1;
            r2_sq <= n2_sq[31:0];
            r2_ap <= r1_ap;
        end
    end

    //--------------------------------------------------------------------
    // S3: scale first term, second-order product
    //--------------------------------------------------------------------
    logic signed [22:0] r3_v1;
    logic signed [36:0] r3_m2, n3_m2;
    logic signed [33:0] n3_v1;
    logic [RAW_W-1:0]   r3_ap;

    assign n3_v1 = r2_m1 >>> 11;
    assign n3_m2 = $signed({1'b0, r2_sq[31:12]}) * w_t3;

    always_ff @(posedge i_clk) begin
        if (w_go[2]) begin
            r3_v1 <= n3_v1[22:0];
            r3_m2 <= n3_m2;
            r3_ap <= r2_ap;
        end
    end

    //--------------------------------------------------------------------
    // S4: fine temperature
    //--------------------------------------------------------------------
    logic signed [23:0] r4_fine;
    logic signed [36:0] n4_v2;
    logic [23:0]        n4_fine;
    logic [RAW_W-1:0]   r4_ap;

    assign n4_v2   = r3_m2 >>> 14;
    assign n4_fine = {r3_v1[22], r3_v1} + n4_v2[23:0];

    always_ff @(posedge i_clk) begin
        if (w_go[3]) begin
            r4_fine <= n4_fine;
            r4_ap   <= r3_ap;
        end
    end

    //--------------------------------------------------------------------
    // S5: temperature output, pressure offset term
    //--------------------------------------------------------------------
    logic signed [26:0]       n5_f, n5_t, n5_tq;
    logic signed [TEMP_W-1:0] r5_temp, n5_temp;
    logic signed [24:0]       r5_a;
    logic [24:0]              n5_a;
    logic [RAW_W-1:0]         r5_ap;

    assign n5_f  = r4_fine;
    assign n5_t  = n5_f * 27'sd5 + 27'sd128;
    assign n5_tq = n5_t >>> 8;
    assign n5_a  = {r4_fine[23], r4_fine} - 25'd128000;

    // Saturate temperature
    always_comb begin
        if (n5_tq < TEMP_MIN) begin
            n5_temp = TEMP_W'(TEMP_MIN);
        end else if (n5_tq > TEMP_MAX) begin
            n5_temp = TEMP_W'(TEMP_MAX);
        end else begin
            n5_temp = n5_tq[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go[4]) begin
            r5_temp <= n5_temp;
            r5_a    <= n5_a;
            r5_ap   <= r4_ap;
        end
    end

    //--------------------------------------------------------------------
    // S6: square of offset, linear products
    //--------------------------------------------------------------------
    logic [44:0]              r6_aa;
    logic signed [49:0]       n6_aa;
    logic signed [40:0]       r6_ap5, r6_ap2, n6_ap5, n6_ap2;
    logic signed [TEMP_W-1:0] r6_temp;
    logic [RAW_W-1:0]         r6_ap;

    assign n6_aa  = r5_a * r5_a;
    assign n6_ap5 = r5_a * w_p5;
    assign n6_ap2 = r5_a * w_p2;

    always_ff @(posedge i_clk) begin
        if (w_go[5]) begin
            r6_aa   <= n6_aa[44:0];
            r6_ap5  <= n6_ap5;
            r6_ap2  <= n6_ap2;
            r6_temp <= r5_temp;
            r6_ap   <= r5_ap;
        end
    end

    //--------------------------------------------------------------------
    // S7: quadratic products
    //--------------------------------------------------------------------
    logic signed [61:0]       r7_b1, r7_c1, n7_b1, n7_c1;
    logic signed [40:0]       r7_ap5, r7_ap2;
    logic signed [TEMP_W-1:0] r7_temp;
    logic [RAW_W-1:0]         r7_ap;

    assign n7_b1 = $signed({1'b0, r6_aa}) * w_p6;
    assign n7_c1 = $signed({1'b0, r6_aa}) * w_p3;

    always_ff @(posedge i_clk) begin
        if (w_go[6]) begin
            r7_b1   <= n7_b1;
            r7_c1   <= n7_c1;
            r7_ap5  <= r6_ap5;
            r7_ap2  <= r6_ap2;
            r7_temp <= r6_temp;
            r7_ap   <= r6_ap;
        end
    end

    //--------------------------------------------------------------------
    // S8: numerator offset and divisor base
    //--------------------------------------------------------------------
    localparam logic signed [55:0] D_BIAS = 56'sd1 <<< 47;

    logic signed [63:0]       r8_b, n8_b1, n8_ap5, n8_p4, n8_b;
    logic signed [61:0]       n8_c1s;
    logic signed [55:0]       r8_d, n8_c1, n8_ap2, n8_d;
    logic signed [TEMP_W-1:0] r8_temp;
    logic [RAW_W-1:0]         r8_ap;

    assign n8_b1  = r7_b1;
    assign n8_ap5 = r7_ap5;
    assign n8_p4  = w_p4;
    assign n8_b   = n8_b1 + (n8_ap5 <<< 17) + (n8_p4 <<< 35);
    assign n8_c1s = r7_c1 >>> 8;
    assign n8_c1  = $signed(n8_c1s[55:0]);
    assign n8_ap2 = r7_ap2;
    assign n8_d   = D_BIAS + n8_c1 + (n8_ap2 <<< 12);

    always_ff @(posedge i_clk) begin
        if (w_go[7]) begin
            r8_b    <= n8_b;
            r8_d    <= n8_d;
            r8_temp <= r7_temp;
            r8_ap   <= r7_ap;
        end
    end

    //--------------------------------------------------------------------
    // S9: numerator, divisor partial products
    //--------------------------------------------------------------------
    logic [20:0]              n9_nk;
    logic signed [63:0]       r9_num, n9_num;
    logic signed [55:0]       n9_hi, r9_hip, n9_hip;
    logic [32:0]              n9_lop;
    logic [15:0]              r9_lop;
    logic signed [TEMP_W-1:0] r9_temp;

    assign n9_nk  = 21'h10_0000 - {1'b0, r8_ap};
    assign n9_num = $signed({12'b0, n9_nk, 31'b0}) - r8_b;
    assign n9_hi  = r8_d >>> 17;
    assign n9_hip = $signed(n9_hi[38:0]) * $signed({1'b0, w_p1});
    assign n9_lop = r8_d[16:0] * w_p1;

    always_ff @(posedge i_clk) begin
        if (w_go[8]) begin
            r9_num  <= n9_num;
            r9_hip  <= n9_hip;
            r9_lop  <= n9_lop[32:17];
            r9_temp <= r8_temp;
        end
    end

    //--------------------------------------------------------------------
    // S10: divisor, numerator magnitude
    //--------------------------------------------------------------------
    logic signed [55:0]       n10_sum, n10_sh;
    logic signed [39:0]       r10_den;
    logic [63:0]              n10_abs;
    logic [62:0]              r10_un;
    logic                     r10_nneg;
    logic signed [TEMP_W-1:0] r10_temp;

    assign n10_sum = r9_hip + $signed({40'b0, r9_lop});
    assign n10_sh  = n10_sum >>> 16;
    assign n10_abs = r9_num[63] ? -r9_num : r9_num;

    always_ff @(posedge i_clk) begin
        if (w_go[9]) begin
            r10_den  <= n10_sh[39:0];
            r10_un   <= n10_abs[62:0];
            r10_nneg <= r9_num[63];
            r10_temp <= r9_temp;
        end
    end

    //--------------------------------------------------------------------
    // S11: divisor magnitude, scaled dividend
    //--------------------------------------------------------------------
    logic [39:0]              n11_ud;
    logic [UD_W-1:0]          r11_ud;
    logic [REM_W-1:0]         r11_n, n11_n;
    logic                     r11_zero, r11_neg;
    logic signed [TEMP_W-1:0] r11_temp;

    assign n11_ud = r10_den[39] ? -r10_den : r10_den;
    assign n11_n  = REM_W'(r10_un) * QUOT_SCALE;

    always_ff @(posedge i_clk) begin
        if (w_go[10]) begin
            r11_ud   <= n11_ud[UD_W-1:0];
            r11_n    <= n11_n;
            r11_zero <= (r10_den == '0);
            r11_neg  <= r10_nneg ^ r10_den[39];
            r11_temp <= r10_temp;
        end
    end

    //--------------------------------------------------------------------
    // S12: flag quotients beyond the divider's range
    //--------------------------------------------------------------------
    logic [REM_W-1:0] r12_rem;
    logic [UD_W-1:0]  r12_ud;
    t_side            r12_side, n12_side;

    always_comb begin
        n12_side.neg  = r11_neg;
        n12_side.zero = r11_zero;
        n12_side.sat  = (r11_n >= (REM_W'(r11_ud) << QUOT_BITS));
        n12_side.temp = r11_temp;
    end

    always_ff @(posedge i_clk) begin
        if (w_go[11]) begin
            r12_rem  <= r11_n;
            r12_ud   <= r11_ud;
            r12_side <= n12_side;
        end
    end

    //--------------------------------------------------------------------
    // Divider
    //--------------------------------------------------------------------
    logic [QUOT_BITS-1:0] w_quot;
    t_side                w_dside;

    bsc_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_go[N_FRONT +: QUOT_BITS]),
        .i_rem  (r12_rem),
        .i_ud   (r12_ud),
        .i_side (r12_side),
        .o_quot (w_quot),
        .o_side (w_dside)
    );

    //--------------------------------------------------------------------
    // P1: clamp and sign the quotient
    //--------------------------------------------------------------------
    logic [QUOT_BITS-1:0] n13_qq;
    logic signed [37:0]   r13_p, n13_p, n13_psh;
    logic signed [24:0]   r13_s;
    t_side                r13_side;

    assign n13_qq  = (w_dside.sat || (w_quot > QUOT_LIMIT)) ? QUOT_LIMIT : w_quot;
    assign n13_p   = w_dside.neg ? -$signed({1'b0, n13_qq}) : $signed({1'b0, n13_qq});
    assign n13_psh = n13_p >>> 13;

    always_ff @(posedge i_clk) begin
        if (w_go[ST_P1]) begin
            r13_p    <= n13_p;
            r13_s    <= n13_psh[24:0];
            r13_side <= w_dside;
        end
    end

    //--------------------------------------------------------------------
    // P2: square of coarse pressure, P8 product
    //--------------------------------------------------------------------
    logic signed [49:0] n14_ss;
    logic [46:0]        r14_ss;
    logic signed [53:0] r14_p8p, n14_p8p;
    logic signed [37:0] r14_p;
    t_side              r14_side;

    assign n14_ss  = r13_s * r13_s;
    assign n14_p8p = r13_p * w_p8;

    always_ff @(posedge i_clk) begin
        if (w_go[ST_P2]) begin
            r14_ss   <= n14_ss[46:0];
            r14_p8p  <= n14_p8p;
            r14_p    <= r13_p;
            r14_side <= r13_side;
        end
    end

    //--------------------------------------------------------------------
    // P3: correction terms
    //--------------------------------------------------------------------
    logic signed [63:0] n15_v1m, n15_v1s;
    logic signed [53:0] n15_v2s;
    logic signed [38:0] r15_v1;
    logic signed [34:0] r15_v2;
    logic signed [37:0] r15_p;
    t_side              r15_side;

    assign n15_v1m = $signed({1'b0, r14_ss}) * w_p9;
    assign n15_v1s = n15_v1m >>> 25;
    assign n15_v2s = r14_p8p >>> 19;

    always_ff @(posedge i_clk) begin
        if (w_go[ST_P3]) begin
            r15_v1   <= n15_v1s[38:0];
            r15_v2   <= n15_v2s[34:0];
            r15_p    <= r14_p;
            r15_side <= r14_side;
        end
    end

    //--------------------------------------------------------------------
    // P4: apply corrections and offset
    //--------------------------------------------------------------------
    logic signed [40:0] n16_ep, n16_ev1, n16_ev2, n16_sum, n16_sh;
    logic signed [33:0] n16_p7, n16_pp, r16_pp;
    t_side              r16_side;

    assign n16_ep  = r15_p;
    assign n16_ev1 = r15_v1;
    assign n16_ev2 = r15_v2;
    assign n16_sum = n16_ep + n16_ev1 + n16_ev2;
    assign n16_sh  = n16_sum >>> 8;
    assign n16_p7  = w_p7;
    assign n16_pp  = $signed(n16_sh[33:0]) + (n16_p7 <<< 4);

    always_ff @(posedge i_clk) begin
        if (w_go[ST_P4]) begin
            r16_pp   <= n16_pp;
            r16_side <= r15_side;
        end
    end

    //--------------------------------------------------------------------
    // Output register: saturate pressure, blank on zero divisor
    //--------------------------------------------------------------------
    logic [PRESS_W-1:0]       r_press, n_press;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_pvalid;

    always_comb begin
        if (r16_side.zero || (r16_pp < 0)) begin
            n_press = '0;
        end else if (r16_pp > PRESS_MAX) begin
            n_press = PRESS_W'(PRESS_MAX);
        end else begin
            n_press = r16_pp[PRESS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go[ST_OUT]) begin
            r_press  <= n_press;
            r_temp   <= r16_side.temp;
            r_pvalid <= ~r16_side.zero;
        end
    end

    assign o_temperature_centi = r_temp;
    assign o_pressure_q8       = r_press;
    assign o_pressure_valid    = r_pvalid;

endmodule

// File: sv/bsc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bsc_pkg; stage enables come from the top level's valid chain.
module bsc_div import bsc_pkg::*; (
    input  logic                 i_clk,
    input  logic [QUOT_BITS-1:0] i_en,
    input  logic [REM_W-1:0]     i_rem,
    input  logic [UD_W-1:0]      i_ud,
    input  t_side                i_side,
    output logic [QUOT_BITS-1:0] o_quot,
    output t_side                o_side
);

    logic [REM_W-1:0]     r_rem  [QUOT_BITS-1];
    logic [UD_W-1:0]      r_ud   [QUOT_BITS-1];
    logic [QUOT_BITS-1:0] r_q    [QUOT_BITS];
    t_side                r_side [QUOT_BITS];

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
        localparam int unsigned J = QUOT_BITS - 1 - k;
        logic [REM_W-1:0]     w_rem;
        logic [REM_W-1:0]     w_dsh;
        logic [UD_W-1:0]      w_ud;
        logic [QUOT_BITS-1:0] w_q;
        logic [QUOT_BITS-1:0] n_q;
        t_side                w_side;
        logic                 w_ge;

        // Take the previous stage, or the ports at the head
        if (k == 0) begin : g_head
            assign w_rem  = i_rem;
            assign w_ud   = i_ud;
            assign w_q    = '0;
            assign w_side = i_side;
        end else begin : g_body
            assign w_rem  = r_rem[k-1];
            assign w_ud   = r_ud[k-1];
            assign w_q    = r_q[k-1];
            assign w_side = r_side[k-1];
        end

        // Trial subtract of the shifted divisor
        assign w_dsh = REM_W'(w_ud) << J;
        assign w_ge  = (w_rem >= w_dsh);

        always_comb begin
            n_q    = w_q;
            n_q[J] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_q[k]    <= n_q;
                r_side[k] <= w_side;
            end
        end

        // The last stage needs no remainder
        if (k < QUOT_BITS - 1) begin : g_keep
            logic [REM_W-1:0] n_rem;
            assign n_rem = w_ge ? (w_rem - w_dsh) : w_rem;
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= n_rem;
                    r_ud[k]  <= w_ud;
                end
            end
        end
    end

    assign o_quot = r_q[QUOT_BITS-1];
    assign o_side = r_side[QUOT_BITS-1];

endmodule

// File: sv/bsc_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the barometric compensation core.
// No package needed; bound to barometric_sensor_compensation_core below.
module bsc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [14:0] o_temperature_centi,
    input logic [24:0]        o_pressure_q8,
    input logic               o_pressure_valid
);

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_temperature_centi)
            && $stable(o_pressure_q8) && $stable(o_pressure_valid))
        else $error("stalled result changed");

    // Zero divisor gives zero pressure
    a_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pressure_valid |-> o_pressure_q8 == 25'd0)
        else $error("pressure not blanked on zero divisor");

    // Temperature stays within its saturation limits
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temperature_centi >= -15'sd4000)
            && (o_temperature_centi <= 15'sd8500))
        else $error("temperature outside saturation limits");

    // Pipe is empty and open right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipe not empty after reset");

endmodule

bind barometric_sensor_compensation_core bsc_chk u_bsc_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_temperature_centi (o_temperature_centi),
    .o_pressure_q8       (o_pressure_q8),
    .o_pressure_valid    (o_pressure_valid)
);

// File: bench/barometric_sensor_compensation_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for barometric_sensor_compensation_core: computes each
// compensated temperature and pressure itself and checks every result in order.
// Depends on bsc_pkg and the core RTL only.
module barometric_sensor_compensation_core_test;
    import bsc_pkg::*;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [PRESS_W-1:0]       press;
        logic                     ok;
    } t_reading;

    // Holds the calibration copy and the readings still owed by the core
    class compensation_board;
        logic [CAL_W-1:0] cal [6];
        t_reading         owed [$];
        int               errors;

        function new();
            foreach (cal[i]) cal[i] = '0;
            errors = 0;
        endfunction

        // Compute the reading for one accepted request and queue it
        function void note_request(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
            longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            longint at, ap, x1, x2, v1, v2, fine, temp, a, b, c, d, hi, lo, den, num, p;
            longint unsigned un, ud, q, r, qq, qlim;
            logic neg;
            t_reading e;
            t1 = longint'(cal[REG_CAL_T1_T2][15:0]);
            t2 = longint'($signed(cal[REG_CAL_T1_T2][31:16]));
            t3 = longint'($signed(cal[REG_CAL_T3_P1][15:0]));
            p1 = longint'(cal[REG_CAL_T3_P1][31:16]);
            p2 = longint'($signed(cal[REG_CAL_P2_P3][15:0]));
            p3 = longint'($signed(cal[REG_CAL_P2_P3][31:16]));
            p4 = longint'($signed(cal[REG_CAL_P4_P5][15:0]));
            p5 = longint'($signed(cal[REG_CAL_P4_P5][31:16]));
            p6 = longint'($signed(cal[REG_CAL_P6_P7][15:0]));
            p7 = longint'($signed(cal[REG_CAL_P6_P7][31:16]));
            p8 = longint'($signed(cal[REG_CAL_P8_P9][15:0]));
            p9 = longint'($signed(cal[REG_CAL_P8_P9][31:16]));
            at = longint'(rt);
            ap = longint'(rp);
            qlim = 64'd68719476736;

            // fine temperature, floor shifts throughout
            x1 = (at >>> 3) - 2 * t1;
            v1 = (x1 * t2) >>> 11;
            x2 = (at >>> 4) - t1;
            v2 = (((x2 * x2) >>> 12) * t3) >>> 14;
            fine = v1 + v2;
            temp = (fine * 5 + 128) >>> 8;
            if (temp < TEMP_MIN) temp = TEMP_MIN;
            if (temp > TEMP_MAX) temp = TEMP_MAX;

            // pressure divisor and dividend
            a = fine - 128000;
            b = a * a * p6 + a * p5 * 131072 + p4 * (longint'(1) << 35);
            c = ((a * a * p3) >>> 8) + a * p2 * 4096;
            d = (longint'(1) << 47) + c;
            hi = d >>> 17;
            lo = d & 64'h1FFFF;
            den = (hi * p1 + ((lo * p1) >>> 17)) >>> 16;

            e.ok = 1'b1;
            if (den == 0) begin
                e.ok = 1'b0;
                p = 0;
            end else begin
                num = (1048576 - ap) * (longint'(1) << 31) - b;
                un = (num < 0) ? longint'(-num) : num;
                ud = (den < 0) ? longint'(-den) : den;
                neg = (num < 0) != (den < 0);
                q = un / ud;
                r = un % ud;
                if (q > qlim / 3125 + 1) qq = qlim;
                else qq = q * 3125 + (r * 3125) / ud;
                if (qq > qlim) qq = qlim;
                p = neg ? -longint'(qq) : longint'(qq);
                // second-order correction and offset
                v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                v2 = (p8 * p) >>> 19;
                p = ((p + v1 + v2) >>> 8) + p7 * 16;
                if (p < 0) p = 0;
                if (p > PRESS_MAX) p = PRESS_MAX;
            end
            e.temp = temp[TEMP_W-1:0];
            e.press = p[PRESS_W-1:0];
            owed.push_back(e);
        endfunction

        // Compare one accepted reading with the oldest one owed
        function void check_reading(logic signed [TEMP_W-1:0] temp,
                                    logic [PRESS_W-1:0] press, logic ok);
            t_reading e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected reading temp=%0d press=%0d valid=%0b",
                         $time, temp, press, ok);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (temp !== e.temp) begin
                $display("%0t: temperature expected %0d got %0d", $time, e.temp, temp);
                errors++;
            end
            if (press !== e.press) begin
                $display("%0t: pressure expected %0d got %0d", $time, e.press, press);
                errors++;
            end
            if (ok !== e.ok) begin
                $display("%0t: pressure valid expected %0b got %0b", $time, e.ok, ok);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk, i_rst_n;
    logic                     psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]        paddr;
    logic [CAL_W-1:0]         pwdata, prdata;
    logic                     i_in_valid, o_in_stall;
    logic [RAW_W-1:0]         i_raw_temperature, i_raw_pressure;
    logic                     o_out_valid, i_out_stall;
    logic signed [TEMP_W-1:0] o_temperature_centi;
    logic [PRESS_W-1:0]       o_pressure_q8;
    logic                     o_pressure_valid;

    compensation_board board = new();
    logic              quiet;
    int                cycles = 0;

    barometric_sensor_compensation_core u_top (.*);

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Drop the run if it hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAIL barometric_sensor_compensation_core");
            $finish;
        end
    end

    // Check every reading the core hands over
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_reading(o_temperature_centi, o_pressure_q8, o_pressure_valid);
    end

    // Receiver stalls in random bursts, none once quiet
    int stall_left;
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Write one calibration register: setup then access cycle
    task automatic write_cal(t_reg_idx idx, logic [CAL_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.cal[idx] = value;
    endtask

    // Write all six registers back to back, then release the bus
    task automatic load_cal(logic [CAL_W-1:0] c0, c1, c2, c3, c4, c5);
        write_cal(REG_CAL_T1_T2, c0);
        write_cal(REG_CAL_T3_P1, c1);
        write_cal(REG_CAL_P2_P3, c2);
        write_cal(REG_CAL_P4_P5, c3);
        write_cal(REG_CAL_P6_P7, c4);
        write_cal(REG_CAL_P8_P9, c5);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Present one request and hold it until accepted, then maybe idle
    task automatic send(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
        i_in_valid <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure <= rp;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(rt, rp);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_corners();
        send(20'h00000, 20'h00000);
        send(20'hFFFFF, 20'hFFFFF);
        send(20'h00000, 20'hFFFFF);
        send(20'hFFFFF, 20'h00000);
        send(20'd519888, 20'd415148);
        send(20'hAAAAA, 20'h55555);
        send(20'h55555, 20'hAAAAA);
        send(20'h80000, 20'h7FFFF);
    endtask

    task automatic send_random(int n);
        repeat (n) begin
            if ($urandom_range(0, 9) < 6)
                send(20'($urandom_range(400000, 600000)),
                     20'($urandom_range(200000, 650000)));
            else
                send(20'($urandom), 20'($urandom));
        end
    endtask

    // Random calibration word: full range, extreme, or near typical
    function automatic logic [15:0] cal_word(logic [15:0] typical);
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return typical + 16'($urandom_range(0, 64)) - 16'd32;
        endcase
    endfunction

    localparam logic [CAL_W-1:0] TYP0 = {16'd26435, 16'd27504};
    localparam logic [CAL_W-1:0] TYP1 = {16'd36477, 16'hFC18};
    localparam logic [CAL_W-1:0] TYP2 = {16'd3024, 16'hD643};
    localparam logic [CAL_W-1:0] TYP3 = {16'd140, 16'd2855};
    localparam logic [CAL_W-1:0] TYP4 = {16'd15500, 16'hFFF9};
    localparam logic [CAL_W-1:0] TYP5 = {16'd6000, 16'hC6F8};
    localparam logic [CAL_W-1:0] MAXW = 32'h7FFF7FFF;
    localparam logic [CAL_W-1:0] MINW = 32'h80008000;

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_in_valid <= 1'b0;
        i_raw_temperature <= '0;
        i_raw_pressure <= '0;
        quiet <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: zero divisor everywhere
        send_corners();
        drain();

        load_cal(TYP0, TYP1, TYP2, TYP3, TYP4, TYP5);
        send_corners();
        send_random(100);
        drain();

        load_cal('1, '1, '1, '1, '1, '1);
        send_corners();
        send_random(60);
        drain();

        load_cal(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW);
        send_corners();
        send_random(60);
        drain();

        load_cal(MINW, MINW, MINW, MINW, MINW, MINW);
        send_corners();
        send_random(60);
        drain();

        // Tiny divisor drives the quotient into saturation
        load_cal(TYP0, {16'd1, TYP1[15:0]}, TYP2, TYP3, TYP4, TYP5);
        send_corners();
        send_random(60);
        drain();

        // Zero divisor with realistic temperature words
        load_cal(TYP0, {16'd0, TYP1[15:0]}, TYP2, TYP3, TYP4, TYP5);
        send_corners();
        send_random(40);
        drain();

        repeat (10) begin
            load_cal({cal_word(TYP0[31:16]), cal_word(TYP0[15:0])},
                     {cal_word(TYP1[31:16]), cal_word(TYP1[15:0])},
                     {cal_word(TYP2[31:16]), cal_word(TYP2[15:0])},
                     {cal_word(TYP3[31:16]), cal_word(TYP3[15:0])},
                     {cal_word(TYP4[31:16]), cal_word(TYP4[15:0])},
                     {cal_word(TYP5[31:16]), cal_word(TYP5[15:0])});
            send_random(80);
            drain();
        end

        // Final stretch at full rate
        load_cal(TYP0, TYP1, TYP2, TYP3, TYP4, TYP5);
        quiet <= 1'b1;
        @(posedge i_clk);
        send_random(150);
        drain();
        repeat (80) @(posedge i_clk);

        if (board.errors == 0)
            $display("PASS barometric_sensor_compensation_core");
        else
            $display("FAIL barometric_sensor_compensation_core");
        $finish;
    end

endmodule
